@@ rtl/core/cscan_pkg.sv @@
// Shared types and constants for the C-SCAN request ordering block.
// No dependencies; imported by cscan_cell and cscan_disk_request_order.
`timescale 1ns / 1ps

package cscan_pkg;

    localparam int MAX_REQUESTS_DEF = 32;
    localparam int TRACK_BITS_DEF   = 16;

    localparam int TRACK_OUT_W = 16;
    localparam int MOVE_W      = 16;
    localparam int TOTAL_W     = 22;
    localparam int TRACKS_W    = 17;

    localparam logic [MOVE_W-1:0]  MOVE_MAX  = 16'hFFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3FFFFF;
    localparam logic [TRACKS_W-1:0] TRACKS_RESET = 17'd200;

    localparam logic REG_HEAD_POSITION = 1'b0;
    localparam logic REG_DISK_TRACKS   = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        logic valid;
        logic gt;
    } cell_flags_t;

endpackage

@@ rtl/core/cscan_disk_request_order.sv @@
// Top level of the C-SCAN request ordering block: control, chain of cells, output word.
// Depends on cscan_pkg and cscan_cell.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_*: one request track per word; s_batch_end marks the last word.
//   Each request is inserted in sorted order into a chain of MAX_REQUESTS+3 cells,
//   one word per cycle while loading. Requests past MAX_REQUESTS are dropped and
//   m_dropped is set on every result of that batch.
//   After the closing word the block inserts track 0, the head position and the end
//   track (ST_ADD0, ST_ADDH, ST_ADDE), then rotates the chain past the points below
//   the head until the first point equal to the head sits in cell 0 (ST_ALIGN).
//   The result words are then registered from cell 0 in ST_EMIT.
//   Results m_*: one word per point, n = accepted requests + 3 words, one per cycle
//   while the receiver is ready; m_final_res marks the last. A stall holds the output
//   register and the chain. s_ready is high only while loading; the first word of the
//   next batch is taken while the last result still waits.
//   Configuration: cfg_we with cfg_index 0 (head position) or 1 (disk tracks),
//   written only between batches.
//   Reset: synchronous, active low; empties the chain, head 0, disk tracks 200.

module cscan_disk_request_order
    import cscan_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
    parameter int TRACK_BITS   = TRACK_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [TRACKS_W-1:0]    cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [TRACK_OUT_W-1:0] s_request_track,
    input  logic                   s_batch_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [TRACK_OUT_W-1:0] m_served_track,
    output logic [MOVE_W-1:0]      m_head_move,
    output logic [TOTAL_W-1:0]     m_total_move,
    output logic                   m_dropped,
    output logic                   m_final_res
);

    localparam int NPOINTS = MAX_REQUESTS + 3;
    localparam int CNT_W   = $clog2(MAX_REQUESTS + 1);
    localparam int TB      = TRACK_BITS;
    localparam int EXT_W   = TB + TRACKS_W;
    localparam int DEXT_W  = TB + MOVE_W;
    localparam int SUM_W   = TB + TOTAL_W + 1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ADD0,
        ST_ADDH,
        ST_ADDE,
        ST_ALIGN,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [TRACK_OUT_W-1:0] head_cfg_reg, head_cfg_next;
    logic [TRACKS_W-1:0]    tracks_cfg_reg, tracks_cfg_next;
    logic [CNT_W-1:0]       req_cnt_reg, req_cnt_next;
    logic                   ovf_reg, ovf_next;
    logic [TB-1:0]          prev_reg, prev_next;
    logic [TOTAL_W-1:0]     sum_reg, sum_next;
    logic                   m_valid_reg, m_valid_next;
    logic [TRACK_OUT_W-1:0] served_reg, served_next;
    logic [MOVE_W-1:0]      move_reg, move_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   dropped_reg, dropped_next;
    logic                   final_reg, final_next;

    cell_op_t               cell_op;
    logic [TB-1:0]          ins_val;
    logic [TB-1:0]          cell_val [NPOINTS];
    cell_flags_t            cell_flags [NPOINTS];

    logic [TB-1:0]          req_trk;
    logic [TB-1:0]          head_trk;
    logic [TB-1:0]          end_trk;
    logic [TB+TRACK_OUT_W-1:0] req_ext;
    logic [TB+TRACK_OUT_W-1:0] head_ext;
    logic [TRACKS_W-1:0]    tracks_m1;
    logic [EXT_W-1:0]       end_ext;
    logic [TB-1:0]          cur;
    logic [TB-1:0]          step_move;
    logic [DEXT_W-1:0]      dist_ext;
    logic [SUM_W-1:0]       sum_ext;
    logic [TB+TRACK_OUT_W-1:0] cur_ext;
    logic                   is_last;
    logic                   fire;

    assign req_ext   = {{TB{1'b0}}, s_request_track};
    assign req_trk   = req_ext[TB-1:0];
    assign head_ext  = {{TB{1'b0}}, head_cfg_reg};
    assign head_trk  = head_ext[TB-1:0];
    assign tracks_m1 = (tracks_cfg_reg == '0) ? '0 : tracks_cfg_reg - 1'b1;
    assign end_ext   = {{TB{1'b0}}, tracks_m1};
    assign end_trk   = (end_ext > {{TRACKS_W{1'b0}}, {TB{1'b1}}}) ? {TB{1'b1}}
                                                                  : end_ext[TB-1:0];

    assign cur       = cell_val[0];
    assign step_move = (cur > prev_reg) ? cur - prev_reg : prev_reg - cur;
    assign dist_ext  = {{MOVE_W{1'b0}}, step_move};
    assign sum_ext   = {{(TB + 1){1'b0}}, sum_reg} + {{(TOTAL_W + 1){1'b0}}, step_move};
    assign cur_ext   = {{TRACK_OUT_W{1'b0}}, cur};
    assign is_last   = cell_flags[0].valid && !cell_flags[1].valid;
    assign fire      = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_LOAD);

    always_comb begin
        state_next      = state_reg;
        head_cfg_next   = head_cfg_reg;
        tracks_cfg_next = tracks_cfg_reg;
        req_cnt_next    = req_cnt_reg;
        ovf_next        = ovf_reg;
        prev_next       = prev_reg;
        sum_next        = sum_reg;
        m_valid_next    = m_valid_reg;
        served_next     = served_reg;
        move_next       = move_reg;
        total_next      = total_reg;
        dropped_next    = dropped_reg;
        final_next      = final_reg;
        cell_op         = CELL_HOLD;
        ins_val         = req_trk;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_HEAD_POSITION: head_cfg_next   = cfg_wdata[TRACK_OUT_W-1:0];
                REG_DISK_TRACKS:   tracks_cfg_next = cfg_wdata;
                default:           head_cfg_next   = head_cfg_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (req_cnt_reg != CNT_W'(MAX_REQUESTS)) begin
                        cell_op      = CELL_INSERT;
                        req_cnt_next = req_cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_batch_end) begin
                        state_next = ST_ADD0;
                    end
                end
            end
            ST_ADD0: begin
                cell_op    = CELL_INSERT;
                ins_val    = '0;
                state_next = ST_ADDH;
            end
            ST_ADDH: begin
                cell_op    = CELL_INSERT;
                ins_val    = head_trk;
                state_next = ST_ADDE;
            end
            ST_ADDE: begin
                cell_op    = CELL_INSERT;
                ins_val    = end_trk;
                state_next = ST_ALIGN;
            end
            ST_ALIGN: begin
                if (cur < head_trk) begin
                    cell_op = CELL_ROTATE;
                end else begin
                    prev_next  = head_trk;
                    sum_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (fire) begin
                    cell_op      = CELL_SHIFT;
                    m_valid_next = 1'b1;
                    served_next  = cur_ext[TRACK_OUT_W-1:0];
                    move_next    = (dist_ext > DEXT_W'(MOVE_MAX)) ? MOVE_MAX
                                                                  : dist_ext[MOVE_W-1:0];
                    sum_next     = (sum_ext > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                 : sum_ext[TOTAL_W-1:0];
                    total_next   = sum_next;
                    dropped_next = ovf_reg;
                    final_next   = is_last;
                    prev_next    = cur;
                    if (is_last) begin
                        req_cnt_next = '0;
                        ovf_next     = 1'b0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            head_cfg_reg   <= '0;
            tracks_cfg_reg <= TRACKS_RESET;
            req_cnt_reg    <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_cfg_reg   <= head_cfg_next;
            tracks_cfg_reg <= tracks_cfg_next;
            req_cnt_reg    <= req_cnt_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
        end
        prev_reg    <= prev_next;
        sum_reg     <= sum_next;
        served_reg  <= served_next;
        move_reg    <= move_next;
        total_reg   <= total_next;
        dropped_reg <= dropped_next;
        final_reg   <= final_next;
    end

    for (genvar i = 0; i < NPOINTS; i++) begin : g_cell
        logic [TB-1:0] lval;
        cell_flags_t   lflags;
        logic [TB-1:0] rval;
        logic          rvalid;

        if (i == 0) begin : g_first
            assign lval   = '0;
            assign lflags = '0;
        end else begin : g_left
            assign lval   = cell_val[i-1];
            assign lflags = cell_flags[i-1];
        end

        if (i == NPOINTS - 1) begin : g_last
            assign rval   = '0;
            assign rvalid = 1'b0;
        end else begin : g_right
            assign rval   = cell_val[i+1];
            assign rvalid = cell_flags[i+1].valid;
        end

        cscan_cell #(
            .TRACK_BITS(TRACK_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (cell_op),
            .ins_val    (ins_val),
            .head_val   (cell_val[0]),
            .left_val   (lval),
            .left_flags (lflags),
            .right_val  (rval),
            .right_valid(rvalid),
            .val        (cell_val[i]),
            .flags      (cell_flags[i])
        );
    end

    assign m_valid        = m_valid_reg;
    assign m_served_track = served_reg;
    assign m_head_move    = move_reg;
    assign m_total_move   = total_reg;
    assign m_dropped      = dropped_reg;
    assign m_final_res    = final_reg;

    a_align_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALIGN) |-> cell_flags[0].valid)
        else $error("align with empty chain");

    a_emit_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !final_reg) |-> (state_reg == ST_EMIT))
        else $error("non-final result pending outside emission");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        req_cnt_reg <= CNT_W'(MAX_REQUESTS))
        else $error("request count past capacity");

    a_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> !cell_flags[MAX_REQUESTS].valid)
        else $error("virtual point slots taken while loading");

    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && fire && is_last) |=> (m_valid_reg && final_reg))
        else $error("last point not flagged final");

endmodule

@@ rtl/core/cscan_cell.sv @@
// One cell of the sorted point chain: holds a track and a valid bit.
// Depends on cscan_pkg for the cell operation code and neighbor flags.
`timescale 1ns / 1ps

module cscan_cell
    import cscan_pkg::*;
#(
    parameter int TRACK_BITS = TRACK_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_op_t              op,
    input  logic [TRACK_BITS-1:0] ins_val,
    input  logic [TRACK_BITS-1:0] head_val,
    input  logic [TRACK_BITS-1:0] left_val,
    input  cell_flags_t           left_flags,
    input  logic [TRACK_BITS-1:0] right_val,
    input  logic                  right_valid,
    output logic [TRACK_BITS-1:0] val,
    output cell_flags_t           flags
);

    logic [TRACK_BITS-1:0] val_reg;
    logic [TRACK_BITS-1:0] val_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  gt;

    assign gt = !valid_reg || (val_reg > ins_val);

    always_comb begin
        val_next   = val_reg;
        valid_next = valid_reg;
        unique case (op)
            CELL_INSERT: begin
                if (gt) begin
                    if (left_flags.gt) begin
                        val_next   = left_val;
                        valid_next = left_flags.valid;
                    end else begin
                        val_next   = ins_val;
                        valid_next = 1'b1;
                    end
                end
            end
            CELL_ROTATE: begin
                if (valid_reg && !right_valid) begin
                    val_next = head_val;
                end else begin
                    val_next = right_val;
                end
            end
            CELL_SHIFT: begin
                val_next   = right_val;
                valid_next = right_valid;
            end
            default: begin
                val_next   = val_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        val_reg <= val_next;
    end

    assign val         = val_reg;
    assign flags.valid = valid_reg;
    assign flags.gt    = gt;

endmodule

@@ test/cscan_order_checker.sv @@
// Scoreboard for cscan_disk_request_order: follows register writes and request words,
// builds the expected C-SCAN service order per batch and checks every result word.
// Depends on cscan_pkg.
`timescale 1ns / 1ps

module cscan_order_checker
    import cscan_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [TRACKS_W-1:0]    cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [TRACK_OUT_W-1:0] s_request_track,
    input  logic                   s_batch_end,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [TRACK_OUT_W-1:0] m_served_track,
    input  logic [MOVE_W-1:0]      m_head_move,
    input  logic [TOTAL_W-1:0]     m_total_move,
    input  logic                   m_dropped,
    input  logic                   m_final_res,
    output int                     fail_count,
    output int                     open_count
);

    localparam int NPTS = MAX_REQUESTS + 3;
    localparam logic [TRACKS_W-1:0] TRACK_TOP = TRACKS_W'(17'h0FFFF);

    typedef struct packed {
        logic [TRACK_OUT_W-1:0] track;
        logic [MOVE_W-1:0]      move;
        logic [TOTAL_W-1:0]     total;
        logic                   dropped;
        logic                   last;
    } served_word_t;

    logic [TRACK_OUT_W-1:0] head_reg;
    logic [TRACKS_W-1:0]    tracks_reg;
    logic [TRACK_OUT_W-1:0] order_pts [NPTS];
    int                     order_n;
    logic                   overflow;
    served_word_t           service_q [$];
    served_word_t           want;
    int                     mismatches = 0;

    assign fail_count = mismatches;

    task automatic insert_point(input logic [TRACK_OUT_W-1:0] v);
        int k;
        k = order_n;
        while (k > 0 && order_pts[k-1] > v) begin
            order_pts[k] = order_pts[k-1];
            k--;
        end
        order_pts[k] = v;
        order_n++;
    endtask

    task automatic close_batch();
        logic [TRACKS_W-1:0]    last_track;
        logic [TRACK_OUT_W-1:0] cur;
        logic [TRACK_OUT_W-1:0] prev;
        logic [TRACK_OUT_W-1:0] step_move;
        int                     start;
        int unsigned            sum;
        served_word_t           w;
        if (tracks_reg == '0) begin
            last_track = '0;
        end else begin
            last_track = tracks_reg - 1'b1;
        end
        if (last_track > TRACK_TOP) begin
            last_track = TRACK_TOP;
        end
        insert_point('0);
        insert_point(head_reg);
        insert_point(last_track[TRACK_OUT_W-1:0]);
        start = 0;
        for (int k = order_n - 1; k >= 0; k--) begin
            if (order_pts[k] == head_reg) begin
                start = k;
            end
        end
        sum = 0;
        prev = order_pts[start];
        for (int i = 0; i < order_n; i++) begin
            cur = order_pts[(start + i) % order_n];
            step_move = (cur > prev) ? cur - prev : prev - cur;
            sum += step_move;
            if (sum > TOTAL_MAX) begin
                sum = TOTAL_MAX;
            end
            w.track   = cur;
            w.move    = (step_move > MOVE_MAX) ? MOVE_MAX : step_move;
            w.total   = TOTAL_W'(sum);
            w.dropped = overflow;
            w.last    = (i == order_n - 1);
            service_q.push_back(w);
            prev = cur;
        end
        order_n = 0;
        overflow = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            head_reg = '0;
            tracks_reg = TRACKS_RESET;
            order_n = 0;
            overflow = 1'b0;
            service_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_HEAD_POSITION) begin
                    head_reg = cfg_wdata[TRACK_OUT_W-1:0];
                end else begin
                    tracks_reg = cfg_wdata;
                end
            end
            if (m_valid && m_ready) begin
                if (service_q.size() == 0) begin
                    $error("result word with nothing expected: served_track %0d",
                           m_served_track);
                    mismatches++;
                end else begin
                    want = service_q.pop_front();
                    if (m_served_track !== want.track) begin
                        $error("served_track: expected %0d, got %0d", want.track,
                               m_served_track);
                        mismatches++;
                    end
                    if (m_head_move !== want.move) begin
                        $error("head_move: expected %0d, got %0d", want.move, m_head_move);
                        mismatches++;
                    end
                    if (m_total_move !== want.total) begin
                        $error("total_move: expected %0d, got %0d", want.total,
                               m_total_move);
                        mismatches++;
                    end
                    if (m_dropped !== want.dropped) begin
                        $error("dropped: expected %0d, got %0d", want.dropped, m_dropped);
                        mismatches++;
                    end
                    if (m_final_res !== want.last) begin
                        $error("final_res: expected %0d, got %0d", want.last, m_final_res);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (order_n < MAX_REQUESTS) begin
                    insert_point(s_request_track);
                end else begin
                    overflow = 1'b1;
                end
                if (s_batch_end) begin
                    close_batch();
                end
            end
        end
        open_count <= service_q.size();
    end

endmodule

@@ test/tb_cscan_disk_request_order.sv @@
// Testbench top for cscan_disk_request_order: drives request batches and register writes
// with random gaps and stalls; cscan_order_checker does the prediction and comparison.
// Depends on cscan_pkg, cscan_disk_request_order and cscan_order_checker.
`timescale 1ns / 1ps

module tb_cscan_disk_request_order;
    import cscan_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 8;
    localparam int RANDOM_WORDS = 50;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [TRACKS_W-1:0]    cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [TRACK_OUT_W-1:0] s_request_track;
    logic                   s_batch_end;
    logic                   m_valid;
    logic                   m_ready;
    logic [TRACK_OUT_W-1:0] m_served_track;
    logic [MOVE_W-1:0]      m_head_move;
    logic [TOTAL_W-1:0]     m_total_move;
    logic                   m_dropped;
    logic                   m_final_res;

    int                     chk_fail;
    int                     chk_open;
    int                     cycle_count;
    int                     words_sent = 0;
    int                     stop_at;
    int                     rx_idle;
    bit                     quiet = 1'b1;
    bit                     hold_rx_req = 1'b0;
    logic [TRACK_OUT_W-1:0] cur_head = '0;
    logic [TRACK_OUT_W-1:0] batch_q [$];

    cscan_disk_request_order dut (.*);

    cscan_order_checker u_checker (
        .fail_count(chk_fail),
        .open_count(chk_open),
        .*
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TRACK_OUT_W-1:0] pick_track();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return cur_head;
            4, 5: return cur_head + TRACK_OUT_W'($urandom_range(0, 6)) - 16'd3;
            default: return TRACK_OUT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [TRACKS_W-1:0] pick_head();
        logic [TRACKS_W-1:0] v;
        v = TRACKS_W'($urandom_range(0, 131071));
        if ($urandom_range(0, 3) == 0) begin
            v[TRACK_OUT_W-1:0] = TRACK_OUT_W'($urandom_range(0, 300));
        end
        return v;
    endfunction

    function automatic logic [TRACKS_W-1:0] pick_tracks();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'h10000;
            2: return TRACKS_W'($urandom_range(65537, 131071));
            3: return TRACKS_W'($urandom_range(1, 16));
            default: return TRACKS_W'($urandom_range(1, 65536));
        endcase
    endfunction

    task automatic send_word(input logic [TRACK_OUT_W-1:0] trk, input logic last);
        int gap;
        s_valid <= 1'b1;
        s_request_track <= trk;
        s_batch_end <= last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_batch();
        foreach (batch_q[i]) begin
            send_word(batch_q[i], i == batch_q.size() - 1);
        end
        batch_q.delete();
    endtask

    task automatic fill_batch(input int len);
        for (int i = 0; i < len; i++) begin
            batch_q.push_back(pick_track());
        end
    endtask

    // hold until every expected word is out and the block has settled
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (chk_open != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [TRACKS_W-1:0] head_data,
                                input logic [TRACKS_W-1:0] tracks_data);
        cfg_we <= 1'b1;
        cfg_index <= REG_HEAD_POSITION;
        cfg_wdata <= head_data;
        @(posedge aclk);
        cfg_index <= REG_DISK_TRACKS;
        cfg_wdata <= tracks_data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_head = head_data[TRACK_OUT_W-1:0];
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[cscan_disk_request_order] ERROR");
        $finish;
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_rx_req) begin
                hold_rx_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
                rx_idle = quiet ? 0 : pick_gap();
                if (rx_idle > 0) begin
                    m_ready <= 1'b0;
                    repeat (rx_idle) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_HEAD_POSITION;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_request_track <= '0;
        s_batch_end <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        batch_q = '{16'd0};
        send_batch();
        drain();
        set_geometry(17'h0FFFF, 17'h10000);
        batch_q = '{16'hFFFF, 16'h0000, 16'h8000};
        send_batch();
        drain();
        set_geometry(17'd100, 17'd0);
        batch_q = '{16'd150, 16'd50, 16'd100, 16'd100};
        send_batch();
        drain();
        set_geometry(17'h10005, 17'h1FFFF);
        batch_q = '{16'hAAAA, 16'h5555, 16'd3};
        send_batch();
        drain();
        set_geometry(17'd1, 17'd1);
        batch_q = '{16'd1, 16'd0};
        send_batch();

        // overflow batch against a stalled receiver, next batch queued behind it
        drain();
        set_geometry(pick_head(), pick_tracks());
        quiet = 1'b0;
        fill_batch(MAX_REQUESTS_DEF + 3);
        hold_rx_req = 1'b1;
        send_batch();
        fill_batch(4);
        send_batch();

        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    drain();
                    set_geometry(pick_head(), pick_tracks());
                end
                2: drain();
                default: ;
            endcase
            quiet = ($urandom_range(0, 4) == 0);
            fill_batch(($urandom_range(0, 9) == 0) ?
                       $urandom_range(MAX_REQUESTS_DEF - 2, MAX_REQUESTS_DEF + 4) :
                       $urandom_range(1, 8));
            send_batch();
        end

        drain();
        repeat (40) @(posedge aclk);
        if (chk_fail == 0) begin
            $display("[cscan_disk_request_order] OK");
        end else begin
            $display("[cscan_disk_request_order] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cscan_pkg.sv
rtl/core/cscan_cell.sv
rtl/core/cscan_disk_request_order.sv
test/cscan_order_checker.sv
test/tb_cscan_disk_request_order.sv
